// ===== hw/rtl/particle_spring_force_macros.svh =====
// Assertion helpers for the spring force block.
`ifndef PARTICLE_SPRING_FORCE_MACROS_SVH
`define PARTICLE_SPRING_FORCE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSF_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("psf check failed");
`define PSF_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("psf check failed");
`else
`define PSF_ASSERT_IMPL(lbl, a, c)
`define PSF_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ===== hw/rtl/psf_pkg.sv =====
package psf_pkg;

    localparam int DW       = 32;
    localparam int CFG_W    = 31;
    localparam int FRAC     = 16;
    localparam int MAG_W    = DW + 1;
    localparam int SUM_W    = 2 * MAG_W + 2;
    localparam int LEN_W    = (SUM_W + 1) / 2;
    localparam int STR_W    = LEN_W;
    localparam int KP_W     = CFG_W + STR_W;
    localparam int NUM_W    = KP_W + MAG_W;
    localparam int DEN_W    = LEN_W + FRAC;
    localparam int QUO_W    = NUM_W;
    localparam int PP_LO_W  = DW + MAG_W;
    localparam int PP_HI_W  = KP_W - DW + MAG_W;
    localparam int IDX_W    = 2;
    localparam int LATENCY  = LEN_W + NUM_W + 8;

    typedef enum logic [IDX_W-1:0] {
        REG_SPRING_CONSTANT = 2'd0,
        REG_REST_LENGTH     = 2'd1,
        REG_SPRING_MODE     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] pos_x;
        logic signed [DW-1:0] pos_y;
        logic signed [DW-1:0] pos_z;
        logic signed [DW-1:0] end_x;
        logic signed [DW-1:0] end_y;
        logic signed [DW-1:0] end_z;
    } psf_in_t;

    typedef struct packed {
        logic signed [DW-1:0] force_x;
        logic signed [DW-1:0] force_y;
        logic signed [DW-1:0] force_z;
        logic                 applied;
        logic                 saturated;
    } psf_out_t;

endpackage

// ===== hw/rtl/psf_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
module psf_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [psf_pkg::SUM_W-1:0]     radicand,
    input  logic [3*psf_pkg::MAG_W+3-1:0] side_in,
    output logic                          out_valid,
    output logic [psf_pkg::LEN_W-1:0]     root,
    output logic [3*psf_pkg::MAG_W+3-1:0] side_out
);
    import psf_pkg::*;
    localparam int SW = 3 * MAG_W + 3;
    localparam int RW = LEN_W + 2;

    logic [LEN_W:1]       vld_reg;
    logic [SUM_W-1:0]     rad_reg  [1:LEN_W];
    logic [RW-1:0]        rem_reg  [1:LEN_W];
    logic [LEN_W-1:0]     q_reg    [1:LEN_W];
    logic [SW-1:0]        side_reg [1:LEN_W];

    for (genvar s = 0; s < LEN_W; s++)
    begin : g_stage
        logic             src_vld;
        logic [SUM_W-1:0] src_rad;
        logic [RW-1:0]    src_rem;
        logic [LEN_W-1:0] src_q;
        logic [SW-1:0]    src_side;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_sh;
        logic             fits;
        if (s == 0)
        begin : g_head
            assign src_vld  = in_valid;
            assign src_rad  = radicand;
            assign src_rem  = '0;
            assign src_q    = '0;
            assign src_side = side_in;
        end
        else
        begin : g_body
            assign src_vld  = vld_reg[s];
            assign src_rad  = rad_reg[s];
            assign src_rem  = rem_reg[s];
            assign src_q    = q_reg[s];
            assign src_side = side_reg[s];
        end
        always_comb
        begin
            rem_sh = {src_rem[RW-3:0], src_rad[SUM_W-1 -: 2]};
            trial  = {src_q, 2'b01};
            fits   = rem_sh >= trial;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= src_vld;
        end
        always_ff @(posedge clk)
        begin
            rad_reg[s+1]  <= src_rad << 2;
            rem_reg[s+1]  <= fits ? rem_sh - trial : rem_sh;
            q_reg[s+1]    <= {src_q[LEN_W-2:0], fits};
            side_reg[s+1] <= src_side;
        end
    end

    assign out_valid = vld_reg[LEN_W];
    assign root      = q_reg[LEN_W];
    assign side_out  = side_reg[LEN_W];
endmodule

// ===== hw/rtl/psf_div.sv =====
// Pipelined restoring divider for the three components, one quotient bit per stage.
module psf_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [3*psf_pkg::NUM_W-1:0]   num,
    input  logic [psf_pkg::DEN_W-1:0]     den,
    input  logic [4:0]                    side_in,
    output logic                          out_valid,
    output logic [3*psf_pkg::QUO_W-1:0]   quo,
    output logic [4:0]                    side_out
);
    import psf_pkg::*;
    localparam int RW = DEN_W + 1;

    logic [NUM_W:1]     vld_reg;
    logic [3*NUM_W-1:0] n_reg    [1:NUM_W];
    logic [3*RW-1:0]    rem_reg  [1:NUM_W];
    logic [DEN_W-1:0]   d_reg    [1:NUM_W];
    logic [4:0]         side_reg [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic               src_vld;
        logic [3*NUM_W-1:0] src_n;
        logic [3*RW-1:0]    src_rem;
        logic [DEN_W-1:0]   src_d;
        logic [4:0]         src_side;
        logic [3*NUM_W-1:0] n_next;
        logic [3*RW-1:0]    rem_next;
        if (s == 0)
        begin : g_head
            assign src_vld  = in_valid;
            assign src_n    = num;
            assign src_rem  = '0;
            assign src_d    = den;
            assign src_side = side_in;
        end
        else
        begin : g_body
            assign src_vld  = vld_reg[s];
            assign src_n    = n_reg[s];
            assign src_rem  = rem_reg[s];
            assign src_d    = d_reg[s];
            assign src_side = side_reg[s];
        end
        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [RW-1:0] sh;
                sh = {src_rem[c*RW +: RW-1], src_n[c*NUM_W + NUM_W-1]};
                if (sh >= {1'b0, src_d})
                begin
                    rem_next[c*RW +: RW] = sh - {1'b0, src_d};
                    n_next[c*NUM_W +: NUM_W] = {src_n[c*NUM_W +: NUM_W-1], 1'b1};
                end
                else
                begin
                    rem_next[c*RW +: RW] = sh;
                    n_next[c*NUM_W +: NUM_W] = {src_n[c*NUM_W +: NUM_W-1], 1'b0};
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= src_vld;
        end
        always_ff @(posedge clk)
        begin
            n_reg[s+1]    <= n_next;
            rem_reg[s+1]  <= rem_next;
            d_reg[s+1]    <= src_d;
            side_reg[s+1] <= src_side;
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign quo       = n_reg[NUM_W];
    assign side_out  = side_reg[NUM_W];
endmodule

// ===== hw/rtl/particle_spring_force.sv =====
// A start beat passes stages 1-3, the square root pipe, stages 4-7, the divider pipe
// and the output register; done is registered together with out_data.
// Throughput: one item per cycle; busy stays low, the pipe never stalls.
// Depth is set by the bit-per-stage square root and divider pipes.
// Reset: async active-low; config returns to k=1.0, rest=1.0, spring mode,
// and all in-flight beats are dropped.
module particle_spring_force
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  psf_pkg::psf_in_t        in_data,
    output logic                    done,
    output psf_pkg::psf_out_t       out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);
    import psf_pkg::*;
`include "particle_spring_force_macros.svh"

    logic [CFG_W-1:0] k_reg, rest_reg;
    logic             mode_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= CFG_W'(65536);
            rest_reg <= CFG_W'(65536);
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SPRING_CONSTANT: k_reg    <= cfg_data[CFG_W-1:0];
                REG_REST_LENGTH:     rest_reg <= cfg_data[CFG_W-1:0];
                REG_SPRING_MODE:     mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: differences, magnitude and sign
    logic               s1_vld_reg;
    logic [MAG_W-1:0]   s1_mag_reg [3];
    logic [2:0]         s1_neg_reg;
    logic signed [MAG_W-1:0] diff [3];

    always_comb
    begin
        diff[0] = MAG_W'(in_data.pos_x) - MAG_W'(in_data.end_x);
        diff[1] = MAG_W'(in_data.pos_y) - MAG_W'(in_data.end_y);
        diff[2] = MAG_W'(in_data.pos_z) - MAG_W'(in_data.end_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_neg_reg[i] <= diff[i][MAG_W-1];
            s1_mag_reg[i] <= diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : diff[i];
        end
    end

    // stage 2: squares
    logic               s2_vld_reg;
    logic [2*MAG_W-1:0] s2_sq_reg [3];
    logic [MAG_W-1:0]   s2_mag_reg [3];
    logic [2:0]         s2_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_reg[i]  <= s1_mag_reg[i] * s1_mag_reg[i];
            s2_mag_reg[i] <= s1_mag_reg[i];
        end
        s2_neg_reg <= s1_neg_reg;
    end

    // stage 3: sum of squares
    logic               s3_vld_reg;
    logic [SUM_W-1:0]   s3_sum_reg;
    logic [3*MAG_W+3-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_sum_reg  <= SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
        s3_side_reg <= {s2_neg_reg, s2_mag_reg[0], s2_mag_reg[1], s2_mag_reg[2]};
    end

    // length
    logic               sq_vld;
    logic [LEN_W-1:0]   len;
    logic [3*MAG_W+3-1:0] sq_side;

    psf_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .radicand  (s3_sum_reg),
        .side_in   (s3_side_reg),
        .out_valid (sq_vld),
        .root      (len),
        .side_out  (sq_side)
    );

    // stage 4: stretch and applied flag
    logic               s4_vld_reg;
    logic [STR_W-1:0]   s4_str_reg;
    logic [LEN_W-1:0]   s4_len_reg;
    logic               s4_app_reg;
    logic               s4_zero_reg;
    logic [3*MAG_W+3-1:0] s4_side_reg;
    logic [STR_W-1:0]   stretch;
    logic               app;
    logic [LEN_W-1:0]   rest_ext;

    always_comb
    begin
        rest_ext = LEN_W'(rest_reg);
        if (mode_reg)
        begin
            app     = len > rest_ext;
            stretch = len - rest_ext;
        end
        else
        begin
            app     = 1'b1;
            stretch = (len >= rest_ext) ? len - rest_ext : rest_ext - len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        s4_str_reg  <= stretch;
        s4_len_reg  <= len;
        s4_app_reg  <= app;
        s4_zero_reg <= !app || (len == '0);
        s4_side_reg <= sq_side;
    end

    // stage 5: k*stretch
    logic               s5_vld_reg;
    logic [KP_W-1:0]    s5_kp_reg;
    logic [LEN_W-1:0]   s5_len_reg;
    logic               s5_app_reg;
    logic               s5_zero_reg;
    logic [3*MAG_W+3-1:0] s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_kp_reg   <= KP_W'(k_reg) * KP_W'(s4_str_reg);
        s5_len_reg  <= s4_len_reg;
        s5_app_reg  <= s4_app_reg;
        s5_zero_reg <= s4_zero_reg;
        s5_side_reg <= s4_side_reg;
    end

    // stage 6: partial products, low and high halves of k*stretch
    logic               s6_vld_reg;
    logic [PP_LO_W-1:0] s6_lo_reg [3];
    logic [PP_HI_W-1:0] s6_hi_reg [3];
    logic [DEN_W-1:0]   s6_den_reg;
    logic [4:0]         s6_side_reg;
    logic [MAG_W-1:0]   m5 [3];
    logic [DEN_W-1:0]   den5;

    always_comb
    begin
        m5[0] = s5_side_reg[2*MAG_W +: MAG_W];
        m5[1] = s5_side_reg[MAG_W +: MAG_W];
        m5[2] = s5_side_reg[0 +: MAG_W];
        den5  = {s5_len_reg, FRAC'(0)};
        if (s5_zero_reg)
            den5 = DEN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else
            s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_lo_reg[i] <= PP_LO_W'(s5_kp_reg[DW-1:0]) * PP_LO_W'(m5[i]);
            s6_hi_reg[i] <= PP_HI_W'(s5_kp_reg[KP_W-1:DW]) * PP_HI_W'(m5[i]);
        end
        s6_den_reg  <= den5;
        s6_side_reg <= {s5_side_reg[3*MAG_W +: 3], s5_app_reg, s5_zero_reg};
    end

    // stage 7: numerators with rounding half; bit 0 of side marks a zero force
    logic               s7_vld_reg;
    logic [3*NUM_W-1:0] s7_num_reg;
    logic [DEN_W-1:0]   s7_den_reg;
    logic [4:0]         s7_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else
            s7_vld_reg <= s6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s7_num_reg[(2-i)*NUM_W +: NUM_W] <= s6_side_reg[0] ? '0 :
                (NUM_W'(s6_hi_reg[i]) << DW) + NUM_W'(s6_lo_reg[i]) +
                NUM_W'(s6_den_reg >> 1);
        s7_den_reg  <= s6_den_reg;
        s7_side_reg <= s6_side_reg;
    end

    // divide
    logic               dv_vld;
    logic [3*QUO_W-1:0] quo;
    logic [4:0]         dv_side;

    psf_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s7_vld_reg),
        .num       (s7_num_reg),
        .den       (s7_den_reg),
        .side_in   (s7_side_reg),
        .out_valid (dv_vld),
        .quo       (quo),
        .side_out  (dv_side)
    );

    // output stage: saturate, sign, output register
    logic               done_reg;
    psf_out_t           out_reg;
    logic [DW-1:0]      fv [3];
    logic [2:0]         satv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QUO_W-1:0] q;
            logic [QUO_W-1:0] lim;
            logic             ng;
            logic [DW-1:0]    v;
            q   = quo[(2-i)*QUO_W +: QUO_W];
            ng  = dv_side[2+i];
            lim = ng ? QUO_W'({1'b0, {(DW-1){1'b1}}}) : QUO_W'({1'b1, {(DW-1){1'b0}}});
            satv[i] = q > lim;
            v = satv[i] ? lim[DW-1:0] : q[DW-1:0];
            fv[i] = ng ? v : DW'(-v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        out_reg.force_x   <= fv[0];
        out_reg.force_y   <= fv[1];
        out_reg.force_z   <= fv[2];
        out_reg.applied   <= dv_side[1];
        out_reg.saturated <= |satv;
    end

    assign done     = done_reg;
    assign out_data = out_reg;

    `PSF_ASSERT_IMPL(a_slack_zero, done && !out_data.applied,
        out_data.force_x == '0 && !out_data.saturated)
    `PSF_ASSERT_NEXT(a_start_flows, start && !busy, s1_vld_reg)
    `PSF_ASSERT_NEXT(a_div_to_done, dv_vld, done)
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for particle_spring_force.
// Positions go in through the start/busy command port. Each accepted beat is run
// through a behavioral force predictor, and the predicted force is queued. The
// force_checker process pops the oldest prediction on every done strobe and
// compares it with the result, field by field.
module tb_top;
    import psf_pkg::*;

    localparam int MAX31 = 32'h7FFF_FFFF;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    psf_in_t  in_data = '0;
    logic     done;
    psf_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predictor's copy of the configuration registers (reset values)
    logic [30:0] stiffness = 31'd65536;
    logic [30:0] rest_len  = 31'd65536;
    logic        bungee    = 1'b0;

    psf_out_t expected_forces[$];
    int       error_count = 0;
    int       send_idle_pct = 0;

    always #2 clk = ~clk;

    particle_spring_force i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_data   (in_data),
        .done      (done),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Hooke force on the particle, exact integer arithmetic in Q16.16.
    // The length is floor(sqrt(sum of squared raw components)).
    // Each component is rounded half away from zero on its magnitude,
    // clipped to the 32-bit signed range, then signed against d.
    function automatic psf_out_t spring_force(psf_in_t p);
        psf_out_t    f;
        logic signed [32:0] d [3];
        logic [32:0]  mag [3];
        logic         neg [3];
        logic [67:0]  sum;
        logic [67:0]  sq;
        logic [33:0]  len;
        logic [33:0]  trial;
        logic [33:0]  stretch;
        logic [33:0]  rest_w;
        logic [127:0] kp, num, den, q, lim, v;
        f = '0;
        rest_w = {3'd0, rest_len};
        d[0] = $signed({p.pos_x[31], p.pos_x}) - $signed({p.end_x[31], p.end_x});
        d[1] = $signed({p.pos_y[31], p.pos_y}) - $signed({p.end_y[31], p.end_y});
        d[2] = $signed({p.pos_z[31], p.pos_z}) - $signed({p.end_z[31], p.end_z});
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = d[i][32];
            mag[i] = neg[i] ? 33'(-d[i]) : 33'(d[i]);
            sum += {35'd0, mag[i]} * {35'd0, mag[i]};
        end
        len = '0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = len | (34'd1 << b);
            sq = {34'd0, trial} * {34'd0, trial};
            if (sq <= sum)
                len = trial;
        end
        if (bungee)
        begin
            // slack bungee (zero length included): nothing applies
            if (len <= rest_w)
                return f;
            stretch = len - rest_w;
        end
        else
            stretch = (len >= rest_w) ? len - rest_w : rest_w - len;
        f.applied = 1'b1;
        if (len == 0)
            return f;
        kp  = 128'(stiffness) * 128'(stretch);
        den = 128'(len) << 16;
        for (int i = 0; i < 3; i++)
        begin
            num = kp * 128'(mag[i]) + (den >> 1);
            q   = num / den;
            lim = neg[i] ? 128'(MAX31) : 128'(MAX31) + 1;
            if (q > lim)
            begin
                f.saturated = 1'b1;
                v = lim;
            end
            else
                v = q;
            // force points against d
            if (!neg[i])
                v = -v;
            case (i)
                0: f.force_x = v[31:0];
                1: f.force_y = v[31:0];
                default: f.force_z = v[31:0];
            endcase
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // Result side: the block cannot be held off, so every strobe is one beat.
    always @(posedge clk)
    begin : force_checker
        psf_out_t want;
        if (rst_n && done)
        begin
            if (expected_forces.size() == 0)
                report_mismatch("unexpected result", out_data[31:0], '0);
            else
            begin
                want = expected_forces.pop_front();
                if (out_data.force_x !== want.force_x)
                    report_mismatch("force_x", out_data.force_x, want.force_x);
                if (out_data.force_y !== want.force_y)
                    report_mismatch("force_y", out_data.force_y, want.force_y);
                if (out_data.force_z !== want.force_z)
                    report_mismatch("force_z", out_data.force_z, want.force_z);
                if (out_data.applied !== want.applied)
                    report_mismatch("applied", {31'd0, out_data.applied},
                                    {31'd0, want.applied});
                if (out_data.saturated !== want.saturated)
                    report_mismatch("saturated", {31'd0, out_data.saturated},
                                    {31'd0, want.saturated});
            end
        end
    end

    // Send one beat; idle gaps come before it at the current idle rate.
    // start stays high across back-to-back beats; drain lowers it.
    task automatic send_item(psf_in_t item);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct && gap < 12)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (busy);
        expected_forces.insert(expected_forces.size(), spring_force(item));
    endtask

    task automatic send_pair(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        psf_in_t it;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.end_x = ex; it.end_y = ey; it.end_z = ez;
        send_item(it);
    endtask

    // Wait for the pipe to drain so register writes land while idle
    task automatic drain;
        start <= 1'b0;
        while (expected_forces.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SPRING_CONSTANT: stiffness = value[30:0];
            REG_REST_LENGTH:     rest_len  = value[30:0];
            default:             bungee    = value[0];
        endcase
    endtask

    task automatic set_spring(logic [31:0] k, logic [31:0] rest, logic mode);
        drain();
        write_reg(REG_SPRING_CONSTANT, k);
        write_reg(REG_REST_LENGTH, rest);
        write_reg(REG_SPRING_MODE, {31'd0, mode});
        cfg_valid <= 1'b0;
    endtask

    // Reset values: k = 1.0, rest = 1.0, two-sided spring
    task automatic test_reset_config;
        send_pair(32'h0002_0000, 0, 0, 0, 0, 0);        // stretched
        send_pair(32'h0000_8000, 0, 0, 0, 0, 0);        // compressed
        send_pair(0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0);
        send_pair(5, 5, 5, 5, 5, 5);                    // zero length, applies
    endtask

    task automatic test_bungee;
        set_spring(32'h0002_0000, 32'h0002_0000, 1'b1);
        send_pair(7, 7, 7, 7, 7, 7);                    // zero length: slack
        send_pair(32'h0001_0000, 0, 0, 0, 0, 0);        // inside rest: slack
        send_pair(32'h0002_0000, 0, 0, 0, 0, 0);        // exactly rest: slack
        send_pair(32'hFFFD_0000, 0, 0, 0, 0, 0);        // taut, pulls back
        send_pair(0, 32'h0010_0000, 32'hFFF0_0000, 0, 0, 0);
    endtask

    // Field extremes and clipping at full stiffness and no rest length, then zero stiffness and full-scale bungee
    task automatic test_extremes;
        set_spring(MAX31, 0, 1'b0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(1, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 0);
        set_spring(0, MAX31, 1'b0);                     // zero stiffness
        send_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
        send_pair(3, 4, 0, 0, 0, 0);
        set_spring(MAX31, MAX31, 1'b1);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0);
        send_pair(1, 1, 1, 0, 0, 0);
    endtask

    function automatic logic [31:0] rand_coord(bit near);
        // near: small offsets around a random center keep lengths close to rest
        if (near)
            return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        return $urandom;
    endfunction

    task automatic test_random(int n, int idle_pct);
        psf_in_t it;
        logic [31:0] base;
        bit near;
        send_idle_pct = idle_pct;
        for (int i = 0; i < n; i++)
        begin
            // new settings every so often, extremes among them
            if (i % 40 == 0)
                case ($urandom_range(3))
                    0: set_spring($urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                                  1'($urandom_range(1)));
                    1: set_spring(MAX31, $urandom_range(32'h0002_0000), 1'($urandom_range(1)));
                    2: set_spring($urandom, $urandom, 1'($urandom_range(1)));
                    default: set_spring($urandom_range(32'h0001_0000), 0,
                                        1'($urandom_range(1)));
                endcase
            near = $urandom_range(99) < 70;
            base = near ? $urandom : 32'd0;
            it.pos_x = rand_coord(near); it.end_x = rand_coord(near);
            it.pos_y = rand_coord(near); it.end_y = rand_coord(near);
            it.pos_z = rand_coord(near); it.end_z = rand_coord(near);
            if (near)
            begin
                it.pos_x += base; it.end_x += base;
                it.pos_y += base; it.end_y += base;
                it.pos_z += base; it.end_z += base;
            end
            if ($urandom_range(99) < 5)
                it.end_x = it.pos_x;                    // degenerate axis
            send_item(it);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_bungee();
        test_extremes();
        test_random(180, 19);
        test_random(180, 64);
        test_random(180, 0);
        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
